FILE: rtl/core/deadline_ordered_timer_queue_core_macros.svh
// Assertion macros for the timer queue core.
// Used by the checker module; needs nothing else.
`ifndef DEADLINE_ORDERED_TIMER_QUEUE_CORE_MACROS_SVH
`define DEADLINE_ORDERED_TIMER_QUEUE_CORE_MACROS_SVH

// same-cycle implication
`define DOTQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer queue check failed");

// next-cycle implication
`define DOTQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer queue check failed");

`endif

FILE: rtl/core/dotq_pkg.sv
// Shared types and codes for the deadline-ordered timer queue.
// No dependencies.
package dotq_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int MAX_ADDR_W = 8;

  localparam logic [2:0] OP_SCHEDULE   = 3'd0;
  localparam logic [2:0] OP_SERVICE    = 3'd1;
  localparam logic [2:0] OP_CANCEL_ORD = 3'd2;
  localparam logic [2:0] OP_CANCEL_DPD = 3'd3;
  localparam logic [2:0] OP_QUERY      = 3'd4;
  localparam logic [2:0] OP_FLUSH      = 3'd5;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_EMPTY       = 3'd1;
  localparam logic [2:0] ST_NOT_EXPIRED = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
  localparam logic [2:0] ST_FULL        = 3'd4;
  localparam logic [2:0] ST_DUPLICATE   = 3'd5;

  localparam logic CFG_DPD_MASK = 1'b0;
  localparam logic CFG_RTX_KIND = 1'b1;

  typedef struct packed {
    logic [31:0] deadline;
    logic [3:0]  kind;
    logic [11:0] owner;
    logic        owned;
  } entry_t;

  typedef struct packed {
    logic                  we;
    logic [MAX_ADDR_W-1:0] waddr;
    logic [MAX_ADDR_W-1:0] raddr;
    entry_t                wdata;
  } mem_req_t;

endpackage

FILE: rtl/core/dotq_ifs.sv
// Channel interfaces of the timer queue: request, response, config write.
// No dependencies.
interface dotq_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] now_time;
  logic [23:0] delay;
  logic [3:0]  event_kind;
  logic [11:0] owner_id;
  logic        has_owner;
  modport source (output valid, operation, now_time, delay, event_kind, owner_id,
                  has_owner, input ready);
  modport sink (input valid, operation, now_time, delay, event_kind, owner_id,
                has_owner, output ready);
endinterface

interface dotq_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  out_kind;
  logic [11:0] out_owner;
  logic        out_has_owner;
  logic [31:0] time_left;
  logic        retransmit_cleared;
  modport source (output valid, status, out_kind, out_owner, out_has_owner, time_left,
                  retransmit_cleared, input ready);
  modport sink (input valid, status, out_kind, out_owner, out_has_owner, time_left,
                retransmit_cleared, output ready);
endinterface

interface dotq_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/deadline_ordered_timer_queue_core.sv
// Deadline-ordered timer queue: sequencer over the entry store.
// Depends on dotq_pkg, dotq_ifs, dotq_mem.
//
// Usage: requests arrive on req (valid/ready), one result per request leaves
// on rsp (valid/ready). cfg writes dpd_kind_mask (index 0) and
// retransmit_kind (index 1); cfg is always ready; the user must write it
// only while the core is idle, as the core itself does not enforce this.
// Each request is walked by one sequencer over an entry store with one
// write port and a registered read port; each entry visited takes a read
// state and an evaluate or write state. Steps per request:
//   flush, unknown op, empty service or query: straight to the output
//   query, service of an unexpired head: read and evaluate the head
//   service pop: read the head, then shift the rest down one slot
//   schedule: write directly into an empty queue, else scan for the
//     position, shift later entries up, write; duplicate or full: scan only
//   cancel: scan for the match, shift later entries down on a hit
// req.ready is high only when the sequencer is idle.
// Reset empties the queue and clears both registers; entries are not
// cleared since only entries below the fill count are ever read.
// When rsp stalls, the result waits in the output register; the next
// request is still taken, and its result waits in S_OUT until taken.
module deadline_ordered_timer_queue_core #(
  parameter int QUEUE_DEPTH = dotq_pkg::DEFAULT_DEPTH
) (
  input logic      clk,
  input logic      rst,
  dotq_req_if.sink   req,
  dotq_rsp_if.source rsp,
  dotq_cfg_if.sink   cfg
);
  import dotq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_EV, S_UP_RD, S_UP_WR, S_NEW_WR,
    S_HEAD_RD, S_HEAD_EV, S_DN_RD, S_DN_WR, S_OUT
  } state_t;

  state_t      state;
  logic [CW-1:0] count, idx, pos;
  logic        pos_found;
  logic [2:0]  op;
  logic [31:0] now_r, dl;
  logic [3:0]  kind_r;
  logic [11:0] owner_r;
  logic        owned_r, cls_r;
  logic [15:0] dpd_mask;
  logic [3:0]  rtx_kind;

  logic [2:0]  res_status;
  logic [3:0]  res_kind;
  logic [11:0] res_owner;
  logic        res_owned;
  logic [31:0] res_time;
  logic        res_rtx;

  mem_req_t    mreq;
  entry_t      rdata;

  logic [32:0] sum;
  logic [32:0] diff;
  logic        ge, nz, match, last, up_done;
  logic [CW-1:0] pos_sel;
  logic [CW:0] idx_p2;

  dotq_mem #(.DEPTH(QUEUE_DEPTH)) u_mem (.clk(clk), .req(mreq), .rdata(rdata));

  assign sum = {1'b0, req.now_time} + {9'd0, req.delay};

  // shared compare unit: stored deadline against now (head) or new deadline
  assign diff = {1'b0, rdata.deadline} - {1'b0, (state == S_HEAD_EV) ? now_r : dl};
  assign ge = !diff[32];
  assign nz = (diff[31:0] != 32'd0);
  assign match = rdata.owned && (rdata.owner == owner_r) && (dpd_mask[rdata.kind] == cls_r);
  assign last = ((idx + CW'(1)) == count);
  assign pos_sel = (!pos_found && ge) ? idx : pos;
  assign up_done = ((idx - CW'(1)) == pos);
  assign idx_p2 = {1'b0, idx} + (CW+1)'(2);

  always_comb begin
    mreq = '0;
    case (state)
      S_SCAN_RD: mreq.raddr = MAX_ADDR_W'(idx);
      S_UP_RD:   mreq.raddr = MAX_ADDR_W'(idx - CW'(1));
      S_UP_WR: begin
        mreq.we = 1'b1;
        mreq.waddr = MAX_ADDR_W'(idx);
        mreq.wdata = rdata;
      end
      S_NEW_WR: begin
        mreq.we = 1'b1;
        mreq.waddr = MAX_ADDR_W'(pos);
        mreq.wdata = '{deadline: dl, kind: kind_r,
                       owner: owned_r ? owner_r : 12'd0, owned: owned_r};
      end
      S_DN_RD:   mreq.raddr = MAX_ADDR_W'(idx + CW'(1));
      S_DN_WR: begin
        mreq.we = 1'b1;
        mreq.waddr = MAX_ADDR_W'(idx);
        mreq.wdata = rdata;
      end
      default: mreq = '0;
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      dpd_mask <= '0;
      rtx_kind <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          CFG_DPD_MASK: dpd_mask <= cfg.data;
          CFG_RTX_KIND: rtx_kind <= cfg.data[3:0];
          default: ;
        endcase
      end
      // S_OUT reloads the output register itself
      if (rsp.valid && rsp.ready && (state != S_OUT)) begin
        rsp.valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op <= req.operation;
            now_r <= req.now_time;
            dl <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            kind_r <= req.event_kind;
            owner_r <= req.owner_id;
            owned_r <= req.has_owner;
            idx <= '0;
            pos <= count;
            pos_found <= 1'b0;
            res_status <= ST_OK;
            res_kind <= '0;
            res_owner <= '0;
            res_owned <= 1'b0;
            res_time <= '0;
            res_rtx <= 1'b0;
            case (req.operation)
              OP_SCHEDULE: begin
                cls_r <= dpd_mask[req.event_kind];
                state <= (count == '0) ? S_NEW_WR : S_SCAN_RD;
              end
              OP_SERVICE, OP_QUERY: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state <= S_OUT;
                end else begin
                  state <= S_HEAD_RD;
                end
              end
              OP_CANCEL_ORD, OP_CANCEL_DPD: begin
                cls_r <= (req.operation == OP_CANCEL_DPD);
                res_status <= ST_NOT_FOUND;
                state <= (count == '0) ? S_OUT : S_SCAN_RD;
              end
              OP_FLUSH: begin
                count <= '0;
                state <= S_OUT;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_SCAN_RD: state <= S_SCAN_EV;
        S_SCAN_EV: begin
          if (op == OP_SCHEDULE) begin
            if (owned_r && match) begin
              res_status <= ST_DUPLICATE;
              state <= S_OUT;
            end else begin
              pos <= pos_sel;
              if (!pos_found && ge) pos_found <= 1'b1;
              if (last) begin
                if (count == CW'(QUEUE_DEPTH)) begin
                  res_status <= ST_FULL;
                  state <= S_OUT;
                end else begin
                  idx <= count;
                  state <= (count == pos_sel) ? S_NEW_WR : S_UP_RD;
                end
              end else begin
                idx <= idx + CW'(1);
                state <= S_SCAN_RD;
              end
            end
          end else if (match) begin
            res_status <= ST_OK;
            res_kind <= rdata.kind;
            res_owner <= rdata.owner;
            res_owned <= rdata.owned;
            res_rtx <= !cls_r && (rdata.kind == rtx_kind);
            if (last) begin
              count <= count - CW'(1);
              state <= S_OUT;
            end else begin
              state <= S_DN_RD;
            end
          end else if (last) begin
            state <= S_OUT;
          end else begin
            idx <= idx + CW'(1);
            state <= S_SCAN_RD;
          end
        end
        S_UP_RD: state <= S_UP_WR;
        S_UP_WR: begin
          idx <= idx - CW'(1);
          state <= up_done ? S_NEW_WR : S_UP_RD;
        end
        S_NEW_WR: begin
          count <= count + CW'(1);
          res_status <= ST_OK;
          state <= S_OUT;
        end
        S_HEAD_RD: state <= S_HEAD_EV;
        S_HEAD_EV: begin
          if (op == OP_SERVICE) begin
            // head deadline above now: not yet due
            if (ge && nz) begin
              res_status <= ST_NOT_EXPIRED;
              res_time <= diff[31:0];
              state <= S_OUT;
            end else begin
              res_kind <= rdata.kind;
              res_owner <= rdata.owner;
              res_owned <= rdata.owned;
              if (count == CW'(1)) begin
                count <= '0;
                state <= S_OUT;
              end else begin
                state <= S_DN_RD;
              end
            end
          end else begin
            res_kind <= rdata.kind;
            res_owner <= rdata.owner;
            res_owned <= rdata.owned;
            res_time <= ge ? diff[31:0] : 32'd0;
            state <= S_OUT;
          end
        end
        S_DN_RD: state <= S_DN_WR;
        S_DN_WR: begin
          idx <= idx + CW'(1);
          if (idx_p2 < {1'b0, count}) begin
            state <= S_DN_RD;
          end else begin
            count <= count - CW'(1);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            rsp.status <= res_status;
            rsp.out_kind <= res_kind;
            rsp.out_owner <= res_owner;
            rsp.out_has_owner <= res_owned;
            rsp.time_left <= res_time;
            rsp.retransmit_cleared <= res_rtx;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/dotq_mem.sv
// Entry store: one write port, one registered read port.
// Depends on dotq_pkg.
module dotq_mem #(
  parameter int DEPTH = dotq_pkg::DEFAULT_DEPTH
) (
  input  logic              clk,
  input  dotq_pkg::mem_req_t req,
  output dotq_pkg::entry_t   rdata
);
  import dotq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    rdata <= mem[req.raddr[AW-1:0]];
  end

endmodule

FILE: rtl/core/dotq_checker.sv
// Port-level checks for the timer queue core, bound to the core module.
// Depends on dotq_pkg and deadline_ordered_timer_queue_core_macros.svh.
`include "deadline_ordered_timer_queue_core_macros.svh"

module dotq_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [2:0]  status,
  input logic [3:0]  out_kind,
  input logic [31:0] time_left,
  input logic        retransmit_cleared
);
  import dotq_pkg::*;

  `DOTQ_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)
  `DOTQ_ASSERT_NEXT(a_busy_after_req, clk, rst, req_valid && req_ready, !req_ready)
  `DOTQ_ASSERT_NOW(a_rtx_only_ok, clk, rst, rsp_valid && (status != ST_OK), !retransmit_cleared)
  `DOTQ_ASSERT_NOW(a_empty_clean, clk, rst, rsp_valid && (status == ST_EMPTY),
                   (time_left == 32'd0) && (out_kind == 4'd0))

endmodule

bind deadline_ordered_timer_queue_core dotq_checker u_dotq_checker (
  .clk(clk),
  .rst(rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .status(rsp.status),
  .out_kind(rsp.out_kind),
  .time_left(rsp.time_left),
  .retransmit_cleared(rsp.retransmit_cleared)
);

FILE: verif/dotq_scoreboard.sv
// Timer queue predictor and result scoreboard.
// Depends on dotq_pkg; used by the testbench top.
`timescale 1ns / 1ps

class dotq_scoreboard;
  typedef struct {
    logic [2:0]  status;
    logic [3:0]  kind;
    logic [11:0] owner;
    logic        owned;
    logic [31:0] left;
    logic        rtx;
  } result_t;

  localparam int DEPTH = dotq_pkg::DEFAULT_DEPTH;

  logic [15:0] dpd_mask;
  logic [3:0]  rtx_kind;
  dotq_pkg::entry_t slots [DEPTH+1];
  int count;
  result_t pending[$];
  int errors;
  int checked;
  int status_seen [8];

  function void clear();
    dpd_mask = '0;
    rtx_kind = '0;
    count = 0;
    pending.delete();
    errors = 0;
    checked = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
  endfunction

  function void write_reg(logic idx, logic [15:0] val);
    if (idx == dotq_pkg::CFG_DPD_MASK) dpd_mask = val;
    else rtx_kind = val[3:0];
  endfunction

  function bit is_dpd(logic [3:0] k);
    return dpd_mask[k];
  endfunction

  function void remove(int pos);
    for (int i = pos; i + 1 < count; i++) slots[i] = slots[i+1];
    count--;
  endfunction

  // note an accepted request and queue its expected result
  function void note_request(logic [2:0] op, logic [31:0] now_t, logic [23:0] dly,
                             logic [3:0] kind, logic [11:0] owner, logic owned);
    result_t r;
    logic [32:0] sum;
    logic [31:0] dl;
    bit cls;
    int pos;
    r = '{dotq_pkg::ST_OK, 0, 0, 0, 0, 0};
    case (op)
      dotq_pkg::OP_SCHEDULE: begin
        sum = {1'b0, now_t} + {9'b0, dly};
        dl = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        cls = is_dpd(kind);
        if (owned)
          for (int i = 0; i < count; i++)
            if (slots[i].owned && slots[i].owner == owner && is_dpd(slots[i].kind) == cls)
              r.status = dotq_pkg::ST_DUPLICATE;
        if (r.status == dotq_pkg::ST_OK && count >= DEPTH) r.status = dotq_pkg::ST_FULL;
        if (r.status == dotq_pkg::ST_OK) begin
          pos = count;
          for (int i = count - 1; i >= 0; i--) if (slots[i].deadline >= dl) pos = i;
          for (int i = count; i > pos; i--) slots[i] = slots[i-1];
          slots[pos] = '{dl, kind, owned ? owner : 12'd0, owned};
          count++;
        end
      end
      dotq_pkg::OP_SERVICE: begin
        if (count == 0) r.status = dotq_pkg::ST_EMPTY;
        else if (now_t < slots[0].deadline) begin
          r.status = dotq_pkg::ST_NOT_EXPIRED;
          r.left = slots[0].deadline - now_t;
        end else begin
          r.kind = slots[0].kind; r.owner = slots[0].owner; r.owned = slots[0].owned;
          remove(0);
        end
      end
      dotq_pkg::OP_CANCEL_ORD, dotq_pkg::OP_CANCEL_DPD: begin
        r.status = dotq_pkg::ST_NOT_FOUND;
        pos = -1;
        for (int i = count - 1; i >= 0; i--)
          if (slots[i].owned && slots[i].owner == owner &&
              is_dpd(slots[i].kind) == (op == dotq_pkg::OP_CANCEL_DPD)) pos = i;
        if (pos >= 0) begin
          r.status = dotq_pkg::ST_OK;
          r.kind = slots[pos].kind; r.owner = slots[pos].owner; r.owned = slots[pos].owned;
          r.rtx = (op == dotq_pkg::OP_CANCEL_ORD) && slots[pos].kind == rtx_kind;
          remove(pos);
        end
      end
      dotq_pkg::OP_QUERY: begin
        if (count == 0) r.status = dotq_pkg::ST_EMPTY;
        else begin
          r.kind = slots[0].kind; r.owner = slots[0].owner; r.owned = slots[0].owned;
          r.left = slots[0].deadline > now_t ? slots[0].deadline - now_t : 32'd0;
        end
      end
      dotq_pkg::OP_FLUSH: count = 0;
      default: ;
    endcase
    pending.push_back(r);
  endfunction

  function void check_result(logic [2:0] st, logic [3:0] kind, logic [11:0] owner,
                             logic owned, logic [31:0] left, logic rtx);
    result_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result status=%0d", $time, st);
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    status_seen[st]++;
    if (st !== e.status) begin
      $display("%0t: status exp %0d got %0d", $time, e.status, st); errors++;
    end
    if (kind !== e.kind) begin
      $display("%0t: out_kind exp %0d got %0d", $time, e.kind, kind); errors++;
    end
    if (owner !== e.owner) begin
      $display("%0t: out_owner exp %0d got %0d", $time, e.owner, owner); errors++;
    end
    if (owned !== e.owned) begin
      $display("%0t: out_has_owner exp %0d got %0d", $time, e.owned, owned); errors++;
    end
    if (left !== e.left) begin
      $display("%0t: time_left exp %0d got %0d", $time, e.left, left); errors++;
    end
    if (rtx !== e.rtx) begin
      $display("%0t: retransmit_cleared exp %0d got %0d", $time, e.rtx, rtx); errors++;
    end
  endfunction
endclass

FILE: verif/testbench.sv
// Top of the timer queue regression: clock, reset, request driver, result sink.
// Depends on dotq_pkg, dotq_ifs, dotq_scoreboard and the core RTL.
`timescale 1ns / 1ps

module testbench;
  import dotq_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;
  int n_requests = 0;
  logic [31:0] base_time = 32'd1000;

  dotq_req_if req ();
  dotq_rsp_if rsp ();
  dotq_cfg_if cfg ();
  dotq_scoreboard board;

  deadline_ordered_timer_queue_core dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  always #6 clk = ~clk;

  // result side: random stall, check on handshake
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready)
        board.check_result(rsp.status, rsp.out_kind, rsp.out_owner, rsp.out_has_owner,
                           rsp.time_left, rsp.retransmit_cleared);
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("deadline_ordered_timer_queue_core regression: fail");
      $finish;
    end
  end

  // valid stays high from one request to the next unless the sender idles
  task automatic send(logic [2:0] op, logic [31:0] now_t, logic [23:0] dly,
                      logic [3:0] kind, logic [11:0] owner, logic owned);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 0;
      @(posedge clk);
    end
    req.valid <= 1; req.operation <= op; req.now_time <= now_t; req.delay <= dly;
    req.event_kind <= kind; req.owner_id <= owner; req.has_owner <= owned;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    board.note_request(op, now_t, dly, kind, owner, owned);
    n_requests++;
  endtask

  task automatic drain();
    req.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg.valid <= 1; cfg.index <= idx; cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    board.write_reg(idx, val);
    cfg.valid <= 0;
    @(posedge clk);
  endtask

  // mostly well-formed traffic over a small owner pool with advancing time
  task automatic random_phase(int n);
    logic [2:0] op;
    logic [23:0] dly;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) op = OP_SCHEDULE;
      else if (pick < 60) op = OP_SERVICE;
      else if (pick < 72) op = OP_CANCEL_ORD;
      else if (pick < 84) op = OP_CANCEL_DPD;
      else if (pick < 95) op = OP_QUERY;
      else if (pick < 97) op = OP_FLUSH;
      else op = 3'($urandom_range(7, 6));
      base_time = base_time + $urandom_range(40);
      if ($urandom_range(19) == 0) base_time = $urandom;
      dly = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(60));
      send(op, base_time, dly, 4'($urandom), ($urandom_range(9) == 0) ? 12'($urandom)
           : 12'($urandom_range(5)), $urandom_range(3) != 0);
    end
  endtask

  initial begin
    req.valid = 0; req.operation = '0; req.now_time = '0; req.delay = '0;
    req.event_kind = '0; req.owner_id = '0; req.has_owner = 0;
    cfg.valid = 0; cfg.index = CFG_DPD_MASK; cfg.data = '0;
    board = new();
    board.clear();
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empties, saturation, tie ordering, duplicate, full, cancels
    write_reg(CFG_DPD_MASK, 16'h8001);
    write_reg(CFG_RTX_KIND, 4'd15);
    send(OP_SERVICE, 0, 0, 0, 0, 0);
    send(OP_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send(OP_CANCEL_ORD, 0, 0, 0, 12'd1, 0);
    send(OP_SCHEDULE, 32'hFFFF_FFF0, 24'hFFFFFF, 4'd15, 12'hFFF, 1);
    send(OP_SCHEDULE, 32'd100, 24'd10, 4'd3, 12'd7, 1);
    send(OP_SCHEDULE, 32'd105, 24'd5, 4'd0, 12'd7, 1);
    send(OP_SCHEDULE, 32'd0, 24'd110, 4'd9, 12'd0, 0);
    send(OP_SCHEDULE, 32'd1, 24'd1, 4'd4, 12'd7, 1);
    send(OP_QUERY, 32'd50, 0, 0, 0, 0);
    send(OP_SERVICE, 32'd50, 0, 0, 0, 0);
    send(OP_SERVICE, 32'd110, 0, 0, 0, 0);
    send(OP_CANCEL_DPD, 0, 0, 0, 12'd7, 0);
    send(OP_CANCEL_ORD, 0, 0, 0, 12'hFFF, 0);
    send(OP_CANCEL_DPD, 0, 0, 0, 12'hFFF, 0);
    send(OP_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 0);
    for (int i = 0; i < 17; i++) send(OP_SCHEDULE, 32'd500, 24'(i), 4'(i), 12'(i), i[0]);
    send(OP_SCHEDULE, 0, 0, 4'd1, 12'd1, 1);
    send(OP_FLUSH, 0, 0, 0, 0, 0);
    send(3'd6, 0, 0, 0, 0, 0);
    send(3'd7, 32'hFFFF_FFFF, 24'hFFFFFF, 4'hF, 12'hFFF, 1);
    drain();

    send_idle_pct = 17; recv_idle_pct = 63;
    write_reg(CFG_DPD_MASK, 16'hFFFF);
    write_reg(CFG_RTX_KIND, 4'd0);
    random_phase(100);
    drain();

    send_idle_pct = 63; recv_idle_pct = 17;
    write_reg(CFG_DPD_MASK, 16'h0000);
    write_reg(CFG_RTX_KIND, 4'($urandom));
    random_phase(80);
    drain();
    write_reg(CFG_DPD_MASK, 16'($urandom));
    write_reg(CFG_RTX_KIND, 4'($urandom));
    random_phase(80);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(CFG_DPD_MASK, 16'h5A5A);
    write_reg(CFG_RTX_KIND, 4'd10);
    random_phase(150);
    drain();

    $display("%0d requests, %0d results checked across 5 register settings and 3 idle mixes",
             n_requests, board.checked);
    $display("status mix ok/empty/notexp/notfound/full/dup: %0d %0d %0d %0d %0d %0d",
             board.status_seen[0], board.status_seen[1], board.status_seen[2],
             board.status_seen[3], board.status_seen[4], board.status_seen[5]);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("deadline_ordered_timer_queue_core regression: pass");
    else
      $display("deadline_ordered_timer_queue_core regression: fail");
    $finish;
  end
endmodule
